>>> hw/rtl/brbd_pkg.sv
package brbd_pkg;

   // field and state types
   typedef logic [7:0]  byte_type;
   typedef logic [23:0] code_type;
   typedef logic [4:0]  pos_type;
   typedef logic [1:0]  kind_type;
   typedef logic [1:0]  status_type;

   // item kinds
   localparam kind_type KIND_PUSH  = 2'd0;
   localparam kind_type KIND_START = 2'd1;
   localparam kind_type KIND_PROB  = 2'd2;
   localparam kind_type KIND_RAW   = 2'd3;

   // result status codes
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_STARVED = 2'd1;
   localparam status_type STATUS_DROPPED = 2'd2;

   // decoder constants
   localparam byte_type RANGE_RESET = 8'd255;
   localparam pos_type  POS_RESET   = 5'b10000;   // -16, two's complement
   localparam int       REFILL_BITS = 16;
   localparam int       START_BYTES = 3;
   localparam int       VALUE_W     = 17;

endpackage

>>> hw/rtl/brbd_byte_ram.sv
// Byte store for the compressed stream: one write port, one read port with
// registered read data.
module brbd_byte_ram
   import brbd_pkg::*;
#(
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  byte_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output byte_type          rd_data
);

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/binary_range_bit_decoder_core.sv
// Binary range decoder with an 8-bit range. Push beats (kind 0) store one
// compressed byte in an internal FIFO, or drop it when the FIFO is full, and
// answer in the cycle after they are taken; so do a start that finds fewer
// than three bytes and a raw read of zero bits. A start reads its three bytes
// one per cycle. A probability beat renormalises the range, refills 16 code
// bits from two FIFO bytes when needed, then splits the range. A raw read of
// n bits renormalises and splits once per bit. A single renormalise/split
// unit is stepped once per decoded bit, and the FIFO RAM delivers one byte
// per cycle. req_tready is low while an item is being worked on.
// Every item gives exactly one result beat; a starved item (status 1)
// leaves all decoder and FIFO state as it was. stream_bytes is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle, which the block does not enforce.
module binary_range_bit_decoder_core
   import brbd_pkg::*;
#(
   parameter int FIFO_DEPTH   = 8,
   parameter int MAX_RAW_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,   // stream_bytes
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // data_byte[7:0], prob[15:8], bit_count[20:16],
                                      // nonzero_adjust[21], zero[23:22]
   input  logic [1:0]  req_tuser,     // kind[1:0]
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // value[16:0], zero[23:17]
   output logic [1:0]  rsp_tuser      // status[1:0]
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int SUM_W  = PTR_W + 1;
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_RAW_BITS + 1);
   localparam int ACC_W  = MAX_RAW_BITS + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_START    = 3'd1;
   localparam logic [2:0] ST_NORM     = 3'd2;
   localparam logic [2:0] ST_FETCH_HI = 3'd3;
   localparam logic [2:0] ST_FETCH_LO = 3'd4;
   localparam logic [2:0] ST_LOW      = 3'd5;
   localparam logic [2:0] ST_SPLIT    = 3'd6;
   localparam logic [2:0] ST_FIN      = 3'd7;

   // committed decoder state
   byte_type              range_ff,   range_in;
   code_type              code_ff,    code_in;
   pos_type               pos_ff,     pos_in;
   logic [23:0]           used_ff,    used_in;
   logic [PTR_W-1:0]      rd_ff,      rd_in;
   logic [FILL_W-1:0]     fill_ff,    fill_in;
   logic [23:0]           stream_ff,  stream_in;

   // working copy, committed when an item ends without starving
   byte_type              range_w_ff, range_w_in;
   code_type              code_w_ff,  code_w_in;
   pos_type               pos_w_ff,   pos_w_in;
   logic [23:0]           used_w_ff,  used_w_in;
   logic [PTR_W-1:0]      rd_w_ff,    rd_w_in;
   logic [FILL_W-1:0]     fill_w_ff,  fill_w_in;

   // item and sequencer registers
   logic [2:0]            state_ff,   state_in;
   kind_type              kind_ff,    kind_in;
   byte_type              prob_ff,    prob_in;
   logic                  adj_ff,     adj_in;
   logic [CNT_W-1:0]      cnt_ff,     cnt_in;
   logic [1:0]            sb_ff,      sb_in;
   byte_type              hi_ff,      hi_in;
   byte_type              low_ff,     low_in;
   logic [ACC_W-1:0]      acc_ff,     acc_in;
   logic [ACC_W-1:0]      res_val_ff, res_val_in;
   status_type            res_st_ff,  res_st_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_val_ff,   rsp_val_in;
   status_type            rsp_st_ff,    rsp_st_in;

   // combinational helpers
   logic                  slot_free;
   logic                  req_fire;
   logic                  emit_en;
   logic [ACC_W-1:0]      emit_val;
   status_type            emit_st;
   logic [ACC_W+VALUE_W-1:0] emit_wide;
   logic                  mem_we;
   logic [PTR_W-1:0]      mem_wa;
   logic [SUM_W-1:0]      wsum;
   byte_type              rdata;
   logic [CNT_W-1:0]      n_clamp;
   logic [2:0]            sh;
   logic signed [5:0]     pos_sum;
   pos_type               pos_n;
   logic                  need_refill;
   logic [31:0]           refill_sh;
   logic [15:0]           prod;
   logic [8:0]            half;
   code_type              edge_v;
   logic                  dbit;
   logic [ACC_W-1:0]      acc_n;
   logic [ACC_W-1:0]      acc_adj;

   // leading-zero count of the range, 7 for a zero range
   function automatic logic [2:0] lead_shift(input byte_type r);
      logic [2:0] n;
      n = 3'd7;
      for (int i = 0; i < 8; i++) begin
         if (r[i]) begin
            n = 3'(7 - i);
         end
      end
      return n;
   endfunction

   // circular pointer advance
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // FIFO storage
   brbd_byte_ram #(
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (req_tdata[7:0]),
      .rd_addr (rd_w_in),
      .rd_data (rdata)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;

   // write address is head plus fill, wrapped
   always_comb begin
      wsum = SUM_W'(rd_ff) + SUM_W'(fill_ff);
      if (wsum >= SUM_W'(FIFO_DEPTH)) begin
         wsum = wsum - SUM_W'(FIFO_DEPTH);
      end
      mem_wa = wsum[PTR_W-1:0];
   end

   // raw bit count, saturated
   always_comb begin
      if (req_tdata[20:16] > 5'(MAX_RAW_BITS)) begin
         n_clamp = CNT_W'(MAX_RAW_BITS);
      end else begin
         n_clamp = req_tdata[16 +: CNT_W];
      end
   end

   // renormalisation: shift, saturating bit position, refill decision
   always_comb begin
      sh          = lead_shift(range_w_ff);
      pos_sum     = {pos_w_ff[4], pos_w_ff} + {3'b000, sh};
      if (pos_sum > 6'sd15) begin
         pos_n = 5'd15;
      end else begin
         pos_n = pos_sum[4:0];
      end
      need_refill = !pos_n[4] && (({1'b0, used_w_ff} + 25'd1) < {1'b0, stream_ff});
      refill_sh   = {16'b0, hi_ff, rdata} << pos_w_ff[3:0];
   end

   // split point and decision; range minus one wraps at 8 bits
   always_comb begin
      prod   = byte_type'(range_w_ff - 8'd1) * prob_ff;
      half   = ({1'b0, range_w_ff} + 9'd1);
      edge_v = {low_ff, 16'b0};
      dbit   = (code_w_ff >= edge_v);
      acc_n  = {acc_ff[ACC_W-2:0], dbit};
      acc_adj = {acc_n[ACC_W-2:0], 1'b0};
      if (acc_adj == '0) begin
         acc_adj = ACC_W'(1);
      end
   end

   // sequencer
   always_comb begin
      range_in   = range_ff;
      code_in    = code_ff;
      pos_in     = pos_ff;
      used_in    = used_ff;
      rd_in      = rd_ff;
      fill_in    = fill_ff;
      range_w_in = range_w_ff;
      code_w_in  = code_w_ff;
      pos_w_in   = pos_w_ff;
      used_w_in  = used_w_ff;
      rd_w_in    = rd_w_ff;
      fill_w_in  = fill_w_ff;
      state_in   = state_ff;
      kind_in    = kind_ff;
      prob_in    = prob_ff;
      adj_in     = adj_ff;
      cnt_in     = cnt_ff;
      sb_in      = sb_ff;
      hi_in      = hi_ff;
      low_in     = low_ff;
      acc_in     = acc_ff;
      res_val_in = res_val_ff;
      res_st_in  = res_st_ff;
      mem_we     = 1'b0;
      emit_en    = 1'b0;
      emit_val   = '0;
      emit_st    = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            // working copy follows the committed state
            range_w_in = range_ff;
            code_w_in  = code_ff;
            pos_w_in   = pos_ff;
            used_w_in  = used_ff;
            rd_w_in    = rd_ff;
            fill_w_in  = fill_ff;
            if (req_fire) begin
               kind_in = req_tuser;
               prob_in = req_tdata[15:8];
               adj_in  = req_tdata[21];
               cnt_in  = n_clamp;
               sb_in   = 2'd0;
               acc_in  = '0;
               case (req_tuser)
                  KIND_PUSH: begin
                     emit_en = 1'b1;
                     if (fill_ff < FILL_W'(FIFO_DEPTH)) begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        emit_st = STATUS_DROPPED;
                     end
                  end
                  KIND_START: begin
                     if (fill_ff < FILL_W'(START_BYTES)) begin
                        emit_en = 1'b1;
                        emit_st = STATUS_STARVED;
                     end else begin
                        state_in = ST_START;
                     end
                  end
                  KIND_PROB: begin
                     state_in = ST_NORM;
                  end
                  default: begin
                     if (n_clamp == '0) begin
                        emit_en  = 1'b1;
                        emit_val = ACC_W'(req_tdata[21]);
                     end else begin
                        state_in = ST_NORM;
                     end
                  end
               endcase
            end
         end
         ST_START: begin
            // one byte per cycle into the code window
            code_w_in = {code_w_ff[15:0], rdata};
            rd_w_in   = ptr_next(rd_w_ff);
            fill_w_in = fill_w_ff - 1'b1;
            sb_in     = sb_ff + 2'd1;
            if (sb_ff == 2'(START_BYTES - 1)) begin
               range_w_in = RANGE_RESET;
               pos_w_in   = POS_RESET;
               used_w_in  = 24'(START_BYTES);
               res_val_in = '0;
               res_st_in  = STATUS_OK;
               state_in   = ST_FIN;
            end
         end
         ST_NORM: begin
            range_w_in = range_w_ff << sh;
            code_w_in  = code_w_ff << sh;
            pos_w_in   = pos_n;
            if (!need_refill) begin
               state_in = ST_LOW;
            end else if (fill_w_ff < FILL_W'(2)) begin
               res_val_in = '0;
               res_st_in  = STATUS_STARVED;
               state_in   = ST_FIN;
            end else begin
               state_in = ST_FETCH_HI;
            end
         end
         ST_FETCH_HI: begin
            hi_in     = rdata;
            rd_w_in   = ptr_next(rd_w_ff);
            fill_w_in = fill_w_ff - 1'b1;
            state_in  = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            code_w_in = code_w_ff | refill_sh[23:0];
            used_w_in = used_w_ff + 24'd2;
            pos_w_in  = pos_w_ff - 5'(REFILL_BITS);
            rd_w_in   = ptr_next(rd_w_ff);
            fill_w_in = fill_w_ff - 1'b1;
            state_in  = ST_LOW;
         end
         ST_LOW: begin
            if (kind_ff == KIND_PROB) begin
               low_in = prod[15:8] + 8'd1;
            end else begin
               low_in = half[8:1];
            end
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (dbit) begin
               range_w_in = range_w_ff - low_ff;
               code_w_in  = code_w_ff - edge_v;
            end else begin
               range_w_in = low_ff;
            end
            res_st_in = STATUS_OK;
            if (kind_ff == KIND_PROB) begin
               res_val_in = ACC_W'(dbit);
               state_in   = ST_FIN;
            end else begin
               acc_in = acc_n;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  res_val_in = adj_ff ? acc_adj : acc_n;
                  state_in   = ST_FIN;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               emit_en  = 1'b1;
               emit_val = res_val_ff;
               emit_st  = res_st_ff;
               if (res_st_ff != STATUS_STARVED) begin
                  range_in = range_w_ff;
                  code_in  = code_w_ff;
                  pos_in   = pos_w_ff;
                  used_in  = used_w_ff;
                  rd_in    = rd_w_ff;
                  fill_in  = fill_w_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration register
   always_comb begin
      stream_in = stream_ff;
      if (csr_wr_en) begin
         stream_in = csr_wr_data;
      end
   end

   // output register
   assign emit_wide = {{VALUE_W{1'b0}}, emit_val};
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = emit_wide[VALUE_W-1:0];
         rsp_st_in    = emit_st;
      end
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         range_ff     <= RANGE_RESET;
         code_ff      <= '0;
         pos_ff       <= POS_RESET;
         used_ff      <= '0;
         rd_ff        <= '0;
         fill_ff      <= '0;
         stream_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         range_ff     <= range_in;
         code_ff      <= code_in;
         pos_ff       <= pos_in;
         used_ff      <= used_in;
         rd_ff        <= rd_in;
         fill_ff      <= fill_in;
         stream_ff    <= stream_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      range_w_ff <= range_w_in;
      code_w_ff  <= code_w_in;
      pos_w_ff   <= pos_w_in;
      used_w_ff  <= used_w_in;
      rd_w_ff    <= rd_w_in;
      fill_w_ff  <= fill_w_in;
      kind_ff    <= kind_in;
      prob_ff    <= prob_in;
      adj_ff     <= adj_in;
      cnt_ff     <= cnt_in;
      sb_ff      <= sb_in;
      hi_ff      <= hi_in;
      low_ff     <= low_in;
      acc_ff     <= acc_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - VALUE_W){1'b0}}, rsp_val_ff};
   assign rsp_tuser  = rsp_st_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FIFO_DEPTH))
      else $error("FIFO fill above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, rd_ff} < SUM_W'(FIFO_DEPTH))
      else $error("FIFO head pointer out of range");

   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START || state_ff == ST_FETCH_HI || state_ff == ST_FETCH_LO)
      |-> (fill_w_ff != '0))
      else $error("byte fetched from empty FIFO");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM) |=> (range_w_ff[7] || range_w_ff == 8'd0))
      else $error("range not renormalised");

   a_starved_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && slot_free && res_st_ff == STATUS_STARVED)
      |=> ($stable(range_ff) && $stable(code_ff) && $stable(fill_ff) && $stable(rd_ff)))
      else $error("starved item changed decoder state");

endmodule

>>> test/tb_binary_range_bit_decoder_core.sv
module tb_binary_range_bit_decoder_core;
   import brbd_pkg::*;

   localparam int FIFO_SLOTS   = 8;
   localparam int RAW_BITS_MAX = 16;
   localparam int PHASE_BEATS  = 270;

   // one request beat, unpacked from req_tdata/req_tuser
   typedef struct packed {
      kind_type   kind;
      byte_type   data;
      byte_type   prob;
      logic [4:0] nbits;
      logic       adj;
   } decode_item_type;

   // one result beat
   typedef struct packed {
      logic [16:0] value;
      status_type  status;
   } decode_result_type;

   // directed row: fixed result used only where typed is set
   typedef struct packed {
      decode_item_type   item;
      logic              typed;
      decode_result_type fixed;
   } directed_row_type;

   // decoder state as the predictor sees it
   typedef struct {
      byte_type rng;
      code_type code;
      int       pos;
      code_type used;
      byte_type fifo [FIFO_SLOTS];
      int       fill;
   } decoder_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = KIND_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   decoder_type       dec;
   code_type          stream_len;
   decode_result_type due_results [$];
   decode_item_type   bus_item;
   logic              bus_typed;
   decode_result_type bus_fixed;
   logic              took;
   logic              calm = 1'b0;
   int                mismatches = 0;
   int                results_checked = 0;
   int                kinds_sent [4] = '{0, 0, 0, 0};
   int                status_seen [4] = '{0, 0, 0, 0};
   int                settings_used = 0;

   // directed stimulus: empty-FIFO start, zero-bit raw reads, filling and
   // overflowing the FIFO, extreme probabilities, saturated bit counts
   directed_row_type directed_plan [25] = '{
      '{'{KIND_START, 8'h00, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_STARVED}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd0,  1'b1}, 1'b1, '{17'd1, STATUS_OK}},
      '{'{KIND_PROB,  8'h00, 8'h00, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h00, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'hFF, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h80, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h7F, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h55, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'hAA, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h01, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'hFE, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h12, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_DROPPED}},
      '{'{KIND_START, 8'h00, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PROB,  8'h00, 8'hFF, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_PROB,  8'h00, 8'h00, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_PROB,  8'h00, 8'h80, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd16, 1'b1}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd31, 1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'h3C, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_PUSH,  8'hC3, 8'h00, 5'd0,  1'b0}, 1'b1, '{17'd0, STATUS_OK}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd17, 1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_PROB,  8'h00, 8'h01, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_START, 8'h00, 8'h00, 5'd0,  1'b0}, 1'b0, '{17'd0, STATUS_OK}},
      '{'{KIND_RAW,   8'h00, 8'h00, 5'd1,  1'b1}, 1'b0, '{17'd0, STATUS_OK}}
   };

   binary_range_bit_decoder_core #(
      .FIFO_DEPTH   (FIFO_SLOTS),
      .MAX_RAW_BITS (RAW_BITS_MAX)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshakes hang
   initial begin
      #8000000;
      $display("binary_range_bit_decoder_core: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= 40)
         $display("ERROR t=%0t result %0d: %s got %0d want %0d",
                  $time, results_checked, what, got, want);
   endtask

   // oldest byte out of the FIFO
   function automatic byte_type pull_byte(inout decoder_type s);
      byte_type b;
      int       i;
      b = s.fifo[0];
      for (i = 0; i < FIFO_SLOTS - 1; i++) s.fifo[i] = s.fifo[i + 1];
      s.fill--;
      return b;
   endfunction

   // normalise the range to bit 7 set; refill 16 code bits once the window
   // has room and the stream still holds two bytes. 0 means starved.
   function automatic logic renorm(inout decoder_type s);
      int          sh;
      byte_type    hi;
      byte_type    lo;
      logic [15:0] pair;
      sh = 0;
      if (s.rng == 8'd0) sh = 7;
      else while (sh < 7 && s.rng[7 - sh] == 1'b0) sh++;
      s.rng  = s.rng << sh;
      s.code = s.code << sh;
      s.pos  = s.pos + sh;
      if (s.pos > 15) s.pos = 15;
      if (s.pos >= 0 && {1'b0, s.used} + 25'd1 < {1'b0, stream_len}) begin
         if (s.fill < 2) return 1'b0;
         hi = pull_byte(s);
         lo = pull_byte(s);
         pair = {hi, lo};
         s.code = s.code | code_type'(32'(pair) << s.pos);
         s.used = s.used + 24'd2;
         s.pos  = s.pos - REFILL_BITS;
      end
      return 1'b1;
   endfunction

   // split the range at low; the upper part decodes a one
   function automatic logic split(inout decoder_type s, input int unsigned low);
      code_type cut;
      cut = {low[7:0], 16'd0};
      if (s.code >= cut) begin
         s.rng  = s.rng - low[7:0];
         s.code = s.code - cut;
         return 1'b1;
      end
      s.rng = low[7:0];
      return 1'b0;
   endfunction

   // decode one beat against the predicted state; a starved beat leaves it
   function automatic decode_result_type decode_item(input decode_item_type it);
      decoder_type       w;
      decode_result_type r;
      int unsigned       v;
      int unsigned       n;
      int unsigned       low;
      int unsigned       i;
      byte_type          b0;
      byte_type          b1;
      byte_type          b2;
      byte_type          rm1;
      w = dec;
      v = 0;
      r.status = STATUS_OK;
      case (it.kind)
         KIND_PUSH: begin
            if (w.fill < FIFO_SLOTS) begin
               w.fifo[w.fill] = it.data;
               w.fill++;
            end else begin
               r.status = STATUS_DROPPED;
            end
         end
         KIND_START: begin
            if (w.fill < START_BYTES) begin
               r.status = STATUS_STARVED;
            end else begin
               b0 = pull_byte(w);
               b1 = pull_byte(w);
               b2 = pull_byte(w);
               w.code = {b0, b1, b2};
               w.rng  = RANGE_RESET;
               w.pos  = int'($signed(POS_RESET));
               w.used = 24'd3;
            end
         end
         KIND_PROB: begin
            if (!renorm(w)) begin
               r.status = STATUS_STARVED;
            end else begin
               rm1 = w.rng - 8'd1;
               low = 1 + ((32'(rm1) * 32'(it.prob)) >> 8);
               v = 32'(split(w, low));
            end
         end
         default: begin
            n = (32'(it.nbits) > RAW_BITS_MAX) ? RAW_BITS_MAX : 32'(it.nbits);
            for (i = 0; i < n && r.status == STATUS_OK; i++) begin
               if (!renorm(w)) begin
                  r.status = STATUS_STARVED;
               end else begin
                  low = (32'(w.rng) + 1) >> 1;
                  v = (v << 1) | 32'(split(w, low));
               end
            end
            if (r.status == STATUS_OK && it.adj) begin
               v = v << 1;
               if (v == 0) v = 1;
            end
            if (r.status != STATUS_OK) v = 0;
         end
      endcase
      if (r.status != STATUS_STARVED) dec = w;
      r.value = v[16:0];
      return r;
   endfunction

   // one clock: note an accepted request, check a delivered result, then
   // pick the next rsp_tready. All sampling sits in this one process.
   task automatic tick();
      decode_result_type want;
      decode_result_type seen;
      @(posedge clock);
      took = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            took = 1'b1;
            want = decode_item(bus_item);
            if (bus_typed) want = bus_fixed;
            due_results.push_back(want);
            kinds_sent[bus_item.kind]++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.value  = rsp_tdata[16:0];
            seen.status = rsp_tuser;
            if (due_results.size() == 0) begin
               report_mismatch("result beat with nothing due, value",
                               32'(seen.value), 0);
            end else begin
               want = due_results.pop_front();
               if (seen.value != want.value)
                  report_mismatch("value", 32'(seen.value), 32'(want.value));
               if (seen.status != want.status)
                  report_mismatch("status", 32'(seen.status), 32'(want.status));
            end
            status_seen[seen.status]++;
            results_checked++;
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= 28);
   endtask

   // present one beat, with a random gap first, and hold it until taken
   task automatic send_item(input decode_item_type it, input logic typed,
                            input decode_result_type fixed);
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(0, 99) < 28) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) tick();
      end
      bus_item  = it;
      bus_typed = typed;
      bus_fixed = fixed;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.adj, it.nbits, it.prob, it.data};
      req_tuser  <= it.kind;
      do tick(); while (!took);
   endtask

   // register write once the block has gone quiet
   task automatic set_stream_bytes(input code_type bytes);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) tick();
      repeat (4) tick();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bytes;
      tick();
      csr_wr_en  <= 1'b0;
      stream_len = bytes;
      settings_used++;
   endtask

   // mostly well-formed traffic: keep the FIFO fed, occasional restarts,
   // then probability and raw reads; a slice of fully random beats
   function automatic decode_item_type next_random_item();
      decode_item_type it;
      int              roll;
      it.data  = byte_type'($urandom_range(0, 255));
      it.prob  = byte_type'($urandom_range(0, 255));
      it.nbits = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 4));
      it.adj   = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         it.kind  = kind_type'($urandom_range(0, 3));
         it.nbits = 5'($urandom_range(0, 31));
      end else if (dec.fill < 2 || (roll < 30 && dec.fill < FIFO_SLOTS)) begin
         it.kind = KIND_PUSH;
      end else if (roll < 35 && dec.fill >= START_BYTES) begin
         it.kind = KIND_START;
      end else if (roll < 70) begin
         it.kind = KIND_PROB;
      end else begin
         it.kind = KIND_RAW;
      end
      return it;
   endfunction

   initial begin
      code_type          stream_plan [7];
      decode_result_type no_result;
      int                row;
      int                phase;
      int                guard;

      // predictor state after reset
      dec.rng  = RANGE_RESET;
      dec.code = '0;
      dec.pos  = int'($signed(POS_RESET));
      dec.used = '0;
      dec.fill = 0;
      foreach (dec.fifo[i]) dec.fifo[i] = '0;
      stream_len = '0;
      no_result  = '0;

      // full size first, then a small stream so the window runs dry, then full size
      // again so refills land at the saturated position
      stream_plan = '{24'hFFFFFF, 24'd30, 24'hFFFFFF, 24'd0, 24'd12,
                      code_type'($urandom_range(0, 200)), 24'hFFFFFF};

      repeat (6) tick();
      reset <= 1'b0;

      set_stream_bytes(24'hFFFFFF);
      for (row = 0; row < 25; row++)
         send_item(directed_plan[row].item, directed_plan[row].typed,
                   directed_plan[row].fixed);

      for (phase = 0; phase < 7; phase++) begin
         calm = (phase == 3);
         set_stream_bytes(stream_plan[phase]);
         repeat (PHASE_BEATS) send_item(next_random_item(), 1'b0, no_result);
      end
      calm = 1'b0;

      // drain
      req_tvalid <= 1'b0;
      guard = 0;
      while (due_results.size() != 0 && guard < 200000) begin
         tick();
         guard++;
      end
      repeat (64) tick();
      if (due_results.size() != 0)
         report_mismatch("results never delivered, count", due_results.size(), 0);

      $display("Sent push %0d, start %0d, prob %0d, raw %0d beats over %0d stream sizes",
               kinds_sent[KIND_PUSH], kinds_sent[KIND_START], kinds_sent[KIND_PROB],
               kinds_sent[KIND_RAW], settings_used);
      $display("Checked %0d results: ok %0d, starved %0d, dropped %0d",
               results_checked, status_seen[STATUS_OK], status_seen[STATUS_STARVED],
               status_seen[STATUS_DROPPED]);
      if (mismatches == 0) begin
         $display("binary_range_bit_decoder_core: match");
      end else begin
         $display("binary_range_bit_decoder_core: mismatch");
      end
      $finish;
   end

endmodule
